### rtl/core/mrut_pkg.sv
// ----------------------------------------------------------------------------
// mrut_pkg
// Shared types and constants for the median range upload trigger.
// ----------------------------------------------------------------------------
package mrut_pkg;

    localparam int NUM_RANGES = 5;   // range fields carried by one request
    localparam int RANGE_W    = 16;
    localparam int RANK_W     = 3;   // holds 0..NUM_RANGES

    localparam int TEMP_W     = 11;
    localparam int HUM_W      = 10;
    localparam int EXT_TEMP_W = 16;  // width of the stored temperature extremes
    localparam int EXT_HUM_W  = 11;  // width of the stored humidity extremes

    localparam int LIMIT_W    = 7;   // upload count limit / stored count field

    // register map, by register index
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd0;
    localparam logic [1:0] REG_DIST_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TEMP_LIMIT  = 2'd2;
    localparam logic [1:0] REG_HUM_LIMIT   = 2'd3;

    localparam logic [LIMIT_W-1:0] RST_COUNT_LIMIT = 7'd48;
    localparam logic [15:0]        RST_DIST_LIMIT  = 16'd100;
    localparam logic [10:0]        RST_TEMP_LIMIT  = 11'd50;
    localparam logic [9:0]         RST_HUM_LIMIT   = 10'd100;

    // cleared values of the running extremes
    localparam logic signed [EXT_TEMP_W-1:0] CLR_TEMP_LOW  = 16'sd10000;
    localparam logic signed [EXT_TEMP_W-1:0] CLR_TEMP_HIGH = -16'sd1000;
    localparam logic [EXT_HUM_W-1:0]         CLR_HUM_LOW   = 11'd1000;
    localparam logic [EXT_HUM_W-1:0]         CLR_HUM_HIGH  = 11'd0;
    localparam logic [RANGE_W-1:0]           CLR_DIST_LOW  = 16'hFFFF;
    localparam logic [RANGE_W-1:0]           CLR_DIST_HIGH = 16'd0;

    typedef logic [NUM_RANGES-1:0][RANGE_W-1:0] t_range_arr;
    typedef logic [NUM_RANGES-1:0][RANK_W-1:0]  t_rank_arr;

    typedef struct packed {
        logic [LIMIT_W-1:0] count_limit;
        logic [15:0]        dist_limit;
        logic [10:0]        temp_limit;
        logic [9:0]         hum_limit;
    } t_cfg;

    typedef struct packed {
        logic upd;    // record one observation
        logic clear;  // return count and extremes to cleared values
    } t_trk_ctl;

endpackage

### rtl/core/mrut_lane.sv
// ----------------------------------------------------------------------------
// mrut_lane
// One lane: validity and rank of its reading among the valid readings.
// ----------------------------------------------------------------------------
module mrut_lane #(
    parameter int LANE = 0,
    parameter int USED = 5
) (
    input  mrut_pkg::t_range_arr          i_ranges,
    output logic                          o_valid,
    output logic [mrut_pkg::RANK_W-1:0]   o_rank
);
    import mrut_pkg::*;

    // ties broken by lane index so every valid lane gets a distinct rank
    always_comb begin
        o_rank = '0;
        for (int j = 0; j < NUM_RANGES; j++) begin
            if (j != LANE && j < USED && i_ranges[j] != '0) begin
                if (i_ranges[j] < i_ranges[LANE] ||
                    (i_ranges[j] == i_ranges[LANE] && j < LANE)) begin
                    o_rank = o_rank + RANK_W'(1);
                end
            end
        end
    end

    assign o_valid = (i_ranges[LANE] != '0);

endmodule

### rtl/core/mrut_merge.sv
// ----------------------------------------------------------------------------
// mrut_merge
// Picks the lane whose rank is the upper median of the valid readings.
// ----------------------------------------------------------------------------
module mrut_merge (
    input  mrut_pkg::t_range_arr               i_ranges,
    input  logic [mrut_pkg::NUM_RANGES-1:0]    i_valid,
    input  mrut_pkg::t_rank_arr                i_rank,
    output logic [mrut_pkg::RANGE_W-1:0]       o_median
);
    import mrut_pkg::*;

    logic [RANK_W-1:0] w_num;
    logic [RANK_W-1:0] w_half;

    always_comb begin
        w_num = '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            w_num = w_num + RANK_W'(i_valid[i]);
        end
    end

    assign w_half = w_num >> 1;

    // no valid lane leaves the result at zero
    always_comb begin
        o_median = '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            if (i_valid[i] && i_rank[i] == w_half) begin
                o_median = o_median | i_ranges[i];
            end
        end
    end

endmodule

### rtl/core/mrut_track.sv
// ----------------------------------------------------------------------------
// mrut_track
// Observation count, running extremes and the upload rule.
// ----------------------------------------------------------------------------
module mrut_track #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mrut_pkg::t_trk_ctl                     i_ctl,
    input  mrut_pkg::t_cfg                         i_cfg,
    input  logic signed [mrut_pkg::TEMP_W-1:0]     i_temp,
    input  logic [mrut_pkg::HUM_W-1:0]             i_hum,
    input  logic [mrut_pkg::RANGE_W-1:0]           i_median,
    output logic                                   o_full,
    output logic [$clog2(CAPACITY+1)-1:0]          o_count,
    output logic                                   o_upload
);
    import mrut_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int THRESH = (9 * CAPACITY) / 10;
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [CNT_W-1:0]                r_count;
    logic signed [EXT_TEMP_W-1:0]    r_temp_low,  r_temp_high;
    logic [EXT_HUM_W-1:0]            r_hum_low,   r_hum_high;
    logic [RANGE_W-1:0]              r_dist_low,  r_dist_high;

    logic signed [EXT_TEMP_W-1:0]    w_temp;
    logic [EXT_HUM_W-1:0]            w_hum;
    logic signed [EXT_TEMP_W:0]      w_temp_diff;
    logic signed [EXT_HUM_W:0]       w_hum_diff;
    logic                            w_count_hit;
    logic                            w_spread_hit;

    assign w_temp = EXT_TEMP_W'(i_temp);
    assign w_hum  = EXT_HUM_W'(i_hum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count     <= '0;
            r_temp_low  <= CLR_TEMP_LOW;
            r_temp_high <= CLR_TEMP_HIGH;
            r_hum_low   <= CLR_HUM_LOW;
            r_hum_high  <= CLR_HUM_HIGH;
            r_dist_low  <= CLR_DIST_LOW;
            r_dist_high <= CLR_DIST_HIGH;
        end else if (i_ctl.upd) begin
            r_count <= r_count + CNT_W'(1);
            if (w_temp < r_temp_low)    r_temp_low  <= w_temp;
            if (w_temp > r_temp_high)   r_temp_high <= w_temp;
            if (w_hum < r_hum_low)      r_hum_low   <= w_hum;
            if (w_hum > r_hum_high)     r_hum_high  <= w_hum;
            if (i_median < r_dist_low)  r_dist_low  <= i_median;
            if (i_median > r_dist_high) r_dist_high <= i_median;
        end
    end

    assign o_full  = (r_count >= CNT_W'(CAPACITY));
    assign o_count = r_count;

    assign w_temp_diff = {r_temp_high[EXT_TEMP_W-1], r_temp_high}
                       - {r_temp_low[EXT_TEMP_W-1], r_temp_low};
    assign w_hum_diff  = {1'b0, r_hum_high} - {1'b0, r_hum_low};

    assign w_count_hit = (r_count > CNT_W'(THRESH))
                      || (CMP_W'(r_count) >= CMP_W'(i_cfg.count_limit));

    assign w_spread_hit = (w_temp_diff > $signed({6'd0, i_cfg.temp_limit}))
                       || (r_dist_high > r_dist_low
                           && (r_dist_high - r_dist_low) > i_cfg.dist_limit)
                       || (w_hum_diff > $signed({2'd0, i_cfg.hum_limit}));

    assign o_upload = w_count_hit || (r_count != '0 && w_spread_hit);

endmodule

### rtl/core/median_range_upload_trigger_unit.sv
// ----------------------------------------------------------------------------
// median_range_upload_trigger_unit
// Median-of-readings range filter with storage count and spread alarm.
// ----------------------------------------------------------------------------
// Input stream: tuser[0] is the command (0 observe, 1 clear), tdata carries
// temperature, humidity and five range readings. Output stream: one result
// per request with the upload flag, stored count, median and drop flag.
// Limits are set through the APB port (index 0..3 at byte address 4*i); the
// user must write them only while the block is idle, as the block does not enforce it.
// An accepted request passes through three registers: lane ranking, then
// lane merge with the count/extreme update, then the output register.
// Throughput is one request per cycle while the receiver is ready; every stage
// holds one request and moves as soon as the stage after it is free or draining.
// A stalled receiver holds the output register; the two upstream stages
// still fill, so up to two more requests are taken before tready drops.
// Reset empties the pipeline, clears count and extremes and loads the
// default limits.
// ----------------------------------------------------------------------------
module median_range_upload_trigger_unit #(
    parameter int CAPACITY = 64,
    parameter int READINGS = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [10:0] temperature, [20:11] humidity, [36:21] range_a, [52:37] range_b,
    // [68:53] range_c, [84:69] range_d, [100:85] range_e, [103:101] zero
    input  logic [103:0] i_s_axis_tdata,
    // [0] command
    input  logic         i_s_axis_tuser,
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [0] upload_needed, [7:1] stored_count, [23:8] median_distance,
    // [24] dropped, [31:25] zero
    output logic [31:0]  o_m_axis_tdata,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mrut_pkg::*;

    localparam int USED  = (READINGS < NUM_RANGES) ? READINGS : NUM_RANGES;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ---------------- configuration ----------------
    t_cfg       r_cfg;
    logic [1:0] w_reg_idx;
    logic       w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_limit <= RST_COUNT_LIMIT;
            r_cfg.dist_limit  <= RST_DIST_LIMIT;
            r_cfg.temp_limit  <= RST_TEMP_LIMIT;
            r_cfg.hum_limit   <= RST_HUM_LIMIT;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_COUNT_LIMIT: r_cfg.count_limit <= pwdata[LIMIT_W-1:0];
                REG_DIST_LIMIT:  r_cfg.dist_limit  <= pwdata[15:0];
                REG_TEMP_LIMIT:  r_cfg.temp_limit  <= pwdata[10:0];
                REG_HUM_LIMIT:   r_cfg.hum_limit   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_COUNT_LIMIT: prdata = {25'd0, r_cfg.count_limit};
            REG_DIST_LIMIT:  prdata = {16'd0, r_cfg.dist_limit};
            REG_TEMP_LIMIT:  prdata = {21'd0, r_cfg.temp_limit};
            REG_HUM_LIMIT:   prdata = {22'd0, r_cfg.hum_limit};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic r_v1, r_v2, r_vo;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_ce1, w_ce2, w_ce3;

    assign w_rdy3 = !r_vo || i_m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_ce1 = i_s_axis_tvalid && w_rdy1;
    assign w_ce2 = r_v1 && w_rdy2;
    assign w_ce3 = r_v2 && w_rdy3;

    assign o_s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_vo <= r_v2;
        end
    end

    // ---------------- stage 1: lanes ----------------
    t_range_arr              w_ranges;
    logic [NUM_RANGES-1:0]   w_lane_valid;
    t_rank_arr               w_lane_rank;

    assign w_ranges[0] = i_s_axis_tdata[36:21];
    assign w_ranges[1] = i_s_axis_tdata[52:37];
    assign w_ranges[2] = i_s_axis_tdata[68:53];
    assign w_ranges[3] = i_s_axis_tdata[84:69];
    assign w_ranges[4] = i_s_axis_tdata[100:85];

    for (genvar g = 0; g < NUM_RANGES; g++) begin : g_lane
        if (g < USED) begin : g_used
            mrut_lane #(
                .LANE (g),
                .USED (USED)
            ) u_lane (
                .i_ranges (w_ranges),
                .o_valid  (w_lane_valid[g]),
                .o_rank   (w_lane_rank[g])
            );
        end else begin : g_off
            assign w_lane_valid[g] = 1'b0;
            assign w_lane_rank[g]  = '0;
        end
    end

    logic                       r_cmd1;
    logic signed [TEMP_W-1:0]   r_temp1;
    logic [HUM_W-1:0]           r_hum1;
    t_range_arr                 r_ranges1;
    logic [NUM_RANGES-1:0]      r_valid1;
    t_rank_arr                  r_rank1;

    always_ff @(posedge i_clk) begin
        if (w_ce1) begin
            r_cmd1    <= i_s_axis_tuser;
            r_temp1   <= i_s_axis_tdata[10:0];
            r_hum1    <= i_s_axis_tdata[20:11];
            r_ranges1 <= w_ranges;
            r_valid1  <= w_lane_valid;
            r_rank1   <= w_lane_rank;
        end
    end

    // ---------------- stage 2: merge and state update ----------------
    logic [RANGE_W-1:0] w_median;
    logic               w_full;
    logic [CNT_W-1:0]   w_count;
    logic               w_upload;
    t_trk_ctl           w_ctl;
    logic               w_drop;
    logic               w_take;

    mrut_merge u_merge (
        .i_ranges (r_ranges1),
        .i_valid  (r_valid1),
        .i_rank   (r_rank1),
        .o_median (w_median)
    );

    assign w_take    = !r_cmd1 && !w_full;
    assign w_drop    = !r_cmd1 && w_full;
    assign w_ctl.upd   = w_ce2 && w_take;
    assign w_ctl.clear = w_ce2 && r_cmd1;

    mrut_track #(
        .CAPACITY (CAPACITY)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .i_temp   (r_temp1),
        .i_hum    (r_hum1),
        .i_median (w_median),
        .o_full   (w_full),
        .o_count  (w_count),
        .o_upload (w_upload)
    );

    logic [RANGE_W-1:0] r_med2;
    logic               r_drop2;

    always_ff @(posedge i_clk) begin
        if (w_ce2) begin
            r_med2  <= w_take ? w_median : '0;
            r_drop2 <= w_drop;
        end
    end

    // ---------------- stage 3: output register ----------------
    // state already reflects the request in stage 2 when it moves out here
    logic [LIMIT_W-1:0] w_count_field;

    if (CNT_W >= LIMIT_W) begin : g_cnt_trunc
        assign w_count_field = w_count[LIMIT_W-1:0];
    end else begin : g_cnt_ext
        assign w_count_field = LIMIT_W'(w_count);
    end

    logic [31:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_ce3) begin
            r_out <= {7'd0, r_drop2, r_med2, w_count_field, w_upload};
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = r_out;

    // ---------------- assertions ----------------
    a_drop_no_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[24]) |-> (o_m_axis_tdata[23:8] == '0))
        else $error("dropped result carries a median");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_count_moves_on_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce2 |=> $stable(w_count))
        else $error("count changed without a request in stage 2");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v1)
        else $error("accepted request lost before stage 1");

endmodule
